@@ design/itsc_pkg.sv @@
// Shared constants, request and register codes, and cell control types
// for the itemset support counter. No dependencies.
package itsc_pkg;

    localparam int NUM_CAND    = 32;
    localparam int MAX_ITEMSET = 8;
    localparam int ITEM_BITS   = 16;
    localparam int COUNT_BITS  = 16;
    localparam int IDX_BITS    = 5;
    localparam int POS_BITS    = 3;
    localparam int SIZE_BITS   = 4;
    localparam int NC_BITS     = 6;
    localparam int REQ_BITS    = 2;
    localparam int CFG_AW      = 2;
    localparam int CFG_DW      = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic [REQ_BITS-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_TXN    = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_REPORT = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_SUP_THRESH = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_SET_LEN    = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_CAND_COUNT = 2'd2;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic                   load;
        logic [POS_BITS-1:0]    pos;
        logic [ITEM_BITS-1:0]   item;
        logic                   txn;
        logic                   eot;
        logic [MAX_ITEMSET-1:0] size_mask;
        logic                   snap;
        logic                   shift;
        logic [COUNT_BITS-1:0]  sup_thresh;
    } t_cell_ctl;

    // Report word handed from a cell to its lower neighbor
    typedef struct packed {
        logic                  flag;
        logic [COUNT_BITS-1:0] count;
    } t_rep;

endpackage

@@ design/itsc_cell.sv @@
// One candidate cell: item table row, seen mask, support count and one
// stage of the report shift chain. Depends on itsc_pkg.
module itsc_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  itsc_pkg::t_cell_ctl i_ctl,
    input  logic                i_sel,
    input  logic                i_in_use,
    input  itsc_pkg::t_rep      i_nb,
    output itsc_pkg::t_rep      o_rep
);
    import itsc_pkg::*;

    logic [ITEM_BITS-1:0]   r_items [MAX_ITEMSET];
    logic [MAX_ITEMSET-1:0] r_seen;
    logic [COUNT_BITS-1:0]  r_count;
    t_rep                   r_rep;

    logic [MAX_ITEMSET-1:0] w_match;
    logic [MAX_ITEMSET-1:0] w_seen_all;
    logic                   w_hit;

    always_comb begin
        for (int p = 0; p < MAX_ITEMSET; p++) begin
            w_match[p] = (r_items[p] == i_ctl.item) & i_ctl.size_mask[p] & i_in_use;
        end
        w_seen_all = r_seen | w_match;
        w_hit      = ((w_seen_all & i_ctl.size_mask) == i_ctl.size_mask);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_sel) begin
            r_items[i_ctl.pos] <= i_ctl.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_count <= '0;
            r_rep   <= '0;
        end else begin
            if (i_ctl.load && i_sel && (i_ctl.pos == '0)) begin
                r_seen  <= '0;
                r_count <= '0;
            end else if (i_ctl.txn) begin
                if (i_ctl.eot) begin
                    r_seen <= '0;
                    // saturate at all ones
                    if (i_in_use && w_hit && (r_count != {COUNT_BITS{1'b1}})) begin
                        r_count <= r_count + 1'b1;
                    end
                end else begin
                    r_seen <= w_seen_all;
                end
            end
            if (i_ctl.snap) begin
                r_rep.flag  <= i_in_use && (r_count >= i_ctl.sup_thresh);
                r_rep.count <= r_count;
            end else if (i_ctl.shift) begin
                r_rep <= i_nb;
            end
        end
    end

    assign o_rep = r_rep;

endmodule

@@ design/itsc_report.sv @@
// Report sequencer: walks the cell shift chain from its head and fills the
// output register with frequent candidates or a none-found word. Depends on itsc_pkg.
module itsc_report (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  itsc_pkg::t_rep                      i_head,
    input  logic                                i_any_rest,
    output logic                                o_shift,
    output logic                                o_busy,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [itsc_pkg::IDX_BITS-1:0]       o_index,
    output logic [itsc_pkg::COUNT_BITS-1:0]     o_count,
    output logic                                o_none,
    output logic                                o_last
);
    import itsc_pkg::*;

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_SCAN = 1'b1;

    logic [0:0]            r_state, n_state;
    logic [IDX_BITS-1:0]   r_scan, n_scan;
    logic                  r_out_valid, n_out_valid;
    logic [IDX_BITS-1:0]   r_index, n_index;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_none, n_none;
    logic                  r_last, n_last;
    logic                  w_out_free;
    logic                  w_load;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state  = r_state;
        n_scan   = r_scan;
        n_index  = r_index;
        n_count  = r_count;
        n_none   = r_none;
        n_last   = r_last;
        o_shift  = 1'b0;
        w_load   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SCAN;
                    n_scan  = '0;
                end
            end
            ST_SCAN: begin
                if (i_head.flag) begin
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        n_index = r_scan;
                        n_count = i_head.count;
                        n_none  = 1'b0;
                        n_last  = !i_any_rest;
                        o_shift = 1'b1;
                        n_scan  = r_scan + 1'b1;
                        if (!i_any_rest) begin
                            n_state = ST_IDLE;
                        end
                    end
                end else if (i_any_rest) begin
                    // skip a candidate below threshold
                    o_shift = 1'b1;
                    n_scan  = r_scan + 1'b1;
                end else if (w_out_free) begin
                    w_load  = 1'b1;
                    n_index = '0;
                    n_count = '0;
                    n_none  = 1'b1;
                    n_last  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan      <= n_scan;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_index <= n_index;
        r_count <= n_count;
        r_none  <= n_none;
        r_last  <= n_last;
    end

    assign o_busy      = (r_state == ST_SCAN);
    assign o_out_valid = r_out_valid;
    assign o_index     = r_index;
    assign o_count     = r_count;
    assign o_none      = r_none;
    assign o_last      = r_last;

endmodule

@@ design/itemset_support_counter.sv @@
// Top level of the itemset support counter: configuration registers, the
// chain of candidate cells and the report sequencer. Depends on itsc_pkg,
// itsc_cell and itsc_report.

// Load and transaction words are accepted back to back; every transaction
// item is compared against all candidate positions of all cells in the
// same cycle. A report word snapshots every cell's count and then shifts
// the cell chain toward its head one entry per cycle, holding while a
// frequent entry waits on a backpressured output; no input is taken during
// a report. Reset needs no clearing pass.
module itemset_support_counter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [itsc_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  logic [itsc_pkg::CFG_DW-1:0]        i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // cand_index[4:0], cand_pos[7:5], item_id[23:8]
    input  logic [itsc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // req_type[1:0]
    input  logic [itsc_pkg::REQ_BITS-1:0]      s_axis_tuser,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // frequent_index[4:0], support_count[20:5], zero[23:21]
    output logic [itsc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // none_frequent[0]
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast
);
    import itsc_pkg::*;

    logic [COUNT_BITS-1:0] r_sup_thresh;
    logic [SIZE_BITS-1:0]  r_set_len;
    logic [NC_BITS-1:0]    r_cand_count;

    t_cell_ctl             w_ctl;
    t_rep                  w_rep [NUM_CAND];
    logic [NUM_CAND-1:0]   w_flag;
    logic [NUM_CAND-1:0]   w_in_use;
    logic                  w_accept;
    logic                  w_start;
    logic                  w_shift;
    logic                  w_busy;
    logic                  w_any_rest;
    logic [IDX_BITS-1:0]   w_out_index;
    logic [COUNT_BITS-1:0] w_out_count;
    logic [MAX_ITEMSET-1:0] w_size_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sup_thresh <= COUNT_BITS'(1);
            r_set_len    <= SIZE_BITS'(1);
            r_cand_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SUP_THRESH: r_sup_thresh <= i_cfg_data[COUNT_BITS-1:0];
                CFG_SET_LEN:    r_set_len    <= i_cfg_data[SIZE_BITS-1:0];
                CFG_CAND_COUNT: r_cand_count <= i_cfg_data[NC_BITS-1:0];
                default: ;
            endcase
        end
    end

    // sizes above the table width cover every position
    always_comb begin
        for (int p = 0; p < MAX_ITEMSET; p++) begin
            w_size_mask[p] = (SIZE_BITS'(p) < r_set_len);
        end
    end

    assign s_axis_tready = !w_busy;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_start       = w_accept && (s_axis_tuser == REQ_REPORT);

    always_comb begin
        w_ctl.load       = w_accept && (s_axis_tuser == REQ_LOAD);
        w_ctl.pos        = s_axis_tdata[7:5];
        w_ctl.item       = s_axis_tdata[23:8];
        w_ctl.txn        = w_accept && (s_axis_tuser == REQ_TXN);
        w_ctl.eot        = s_axis_tlast;
        w_ctl.size_mask  = w_size_mask;
        w_ctl.snap       = w_start;
        w_ctl.shift      = w_shift;
        w_ctl.sup_thresh = r_sup_thresh;
    end

    for (genvar g = 0; g < NUM_CAND; g++) begin : g_cell
        t_rep w_nb;
        if (g == NUM_CAND - 1) begin : g_tail
            assign w_nb = '0;
        end else begin : g_mid
            assign w_nb = w_rep[g+1];
        end
        assign w_in_use[g] = (r_cand_count > NC_BITS'(g));
        assign w_flag[g]   = w_rep[g].flag;

        itsc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_sel    (s_axis_tdata[IDX_BITS-1:0] == IDX_BITS'(g)),
            .i_in_use (w_in_use[g]),
            .i_nb     (w_nb),
            .o_rep    (w_rep[g])
        );
    end

    assign w_any_rest = |(w_flag >> 1);

    itsc_report u_report (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_head      (w_rep[0]),
        .i_any_rest  (w_any_rest),
        .o_shift     (w_shift),
        .o_busy      (w_busy),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_index     (w_out_index),
        .o_count     (w_out_count),
        .o_none      (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - IDX_BITS - COUNT_BITS)'(0), w_out_count, w_out_index};

`ifndef SYNTHESIS
    a_no_input_in_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !s_axis_tready)
        else $error("input accepted during report");

    a_report_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> w_busy)
        else $error("report did not start");

    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (w_out_count == '0)))
        else $error("none-found word malformed");

    a_no_snap_while_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_start && w_shift))
        else $error("snapshot and shift together");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

// Self-checking testbench for itemset_support_counter: streams loads,
// transactions and reports, and scores every report word against a predictor.
// Depends on itsc_pkg and the itemset_support_counter design.
module testbench;
    import itsc_pkg::*;

    localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;
    localparam logic [CFG_AW-1:0]   CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int ITEM_TARGET     = 440;

    typedef struct {
        logic [IDX_BITS-1:0]   index;
        logic [COUNT_BITS-1:0] count;
        logic                  none;
        logic                  last;
    } t_freq_word;

    class support_scoreboard;
        logic [ITEM_BITS-1:0]   cand_item [NUM_CAND][MAX_ITEMSET];
        logic [MAX_ITEMSET-1:0] seen_mask [NUM_CAND];
        logic [COUNT_BITS-1:0]  support [NUM_CAND];
        logic [COUNT_BITS-1:0]  sup_thresh;
        logic [SIZE_BITS-1:0]   set_len;
        logic [NC_BITS-1:0]     cand_count;
        t_freq_word             report_q[$];
        int                     errors;

        function void clear();
            foreach (support[i]) begin
                seen_mask[i] = '0;
                support[i]   = '0;
                for (int p = 0; p < MAX_ITEMSET; p++)
                    cand_item[i][p] = '0;
            end
            sup_thresh = 1;
            set_len    = 1;
            cand_count = 0;
            errors     = 0;
            report_q.delete();
        endfunction

        function int used_cands();
            return (cand_count > NUM_CAND) ? NUM_CAND : int'(cand_count);
        endfunction

        function int used_size();
            return (set_len > MAX_ITEMSET) ? MAX_ITEMSET : int'(set_len);
        endfunction

        function int pending();
            return report_q.size();
        endfunction

        function void write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
            case (addr)
                CFG_SUP_THRESH: sup_thresh = data[COUNT_BITS-1:0];
                CFG_SET_LEN:    set_len    = data[SIZE_BITS-1:0];
                CFG_CAND_COUNT: cand_count = data[NC_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Note one accepted input word and queue the report words it causes
        function void note_word(logic [REQ_BITS-1:0] req, logic [IDX_BITS-1:0] idx,
                                logic [POS_BITS-1:0] pos, logic [ITEM_BITS-1:0] item,
                                logic eot);
            int nc;
            int sz;
            int full;
            int last_hit;
            t_freq_word w;
            nc       = used_cands();
            sz       = used_size();
            full     = (1 << sz) - 1;
            last_hit = -1;
            case (req)
                REQ_LOAD: begin
                    cand_item[idx][pos] = item;
                    if (pos == 0) begin
                        support[idx]   = '0;
                        seen_mask[idx] = '0;
                    end
                end
                REQ_TXN: begin
                    for (int i = 0; i < nc; i++)
                        for (int p = 0; p < sz; p++)
                            if (cand_item[i][p] == item)
                                seen_mask[i][p] = 1'b1;
                    if (eot) begin
                        for (int i = 0; i < nc; i++)
                            if ((int'(seen_mask[i]) & full) == full && support[i] != '1)
                                support[i]++;
                        foreach (seen_mask[i])
                            seen_mask[i] = '0;
                    end
                end
                REQ_REPORT: begin
                    for (int i = 0; i < nc; i++)
                        if (support[i] >= sup_thresh)
                            last_hit = i;
                    if (last_hit < 0) begin
                        w = '{index: '0, count: '0, none: 1'b1, last: 1'b1};
                        report_q.push_back(w);
                    end
                    for (int i = 0; i <= last_hit; i++) begin
                        if (support[i] >= sup_thresh) begin
                            w.index = i[IDX_BITS-1:0];
                            w.count = support[i];
                            w.none  = 1'b0;
                            w.last  = (i == last_hit);
                            report_q.push_back(w);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic [IDX_BITS-1:0] index, logic [COUNT_BITS-1:0] count,
                                 logic none, logic last);
            t_freq_word w;
            if (report_q.size() == 0) begin
                $display("%0t: unexpected report word: index %0d count %0d none %0b last %0b",
                         $time, index, count, none, last);
                errors++;
                return;
            end
            w = report_q.pop_front();
            if (w.index !== index) begin
                $display("%0t: frequent_index expected %0d actual %0d", $time, w.index, index);
                errors++;
            end
            if (w.count !== count) begin
                $display("%0t: support_count expected %0d actual %0d", $time, w.count, count);
                errors++;
            end
            if (w.none !== none) begin
                $display("%0t: none_frequent expected %0b actual %0b", $time, w.none, none);
                errors++;
            end
            if (w.last !== last) begin
                $display("%0t: last expected %0b actual %0b", $time, w.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0]       i_cfg_addr    = '0;
    logic [CFG_DW-1:0]       i_cfg_data    = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [REQ_BITS-1:0]     s_axis_tuser  = '0;
    logic                    s_axis_tlast  = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tuser;
    logic                    m_axis_tlast;

    support_scoreboard       sb;
    int                      send_idle_pct = 25;
    int                      recv_idle_pct = 57;
    int                      hold_requests = 0;
    int                      hold_served   = 0;
    int                      hold_left     = 0;
    int                      cycle_count   = 0;
    int                      items_sent    = 0;
    logic                    written [NUM_CAND][MAX_ITEMSET];
    logic [ITEM_BITS-1:0]    item_pool [8];

    itemset_support_counter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: score each accepted word, then pick tready for the next edge
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata[IDX_BITS-1:0], m_axis_tdata[IDX_BITS +: COUNT_BITS],
                          m_axis_tuser, m_axis_tlast);
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [ITEM_BITS-1:0] pool_item();
        if ($urandom_range(4) == 0)
            return ITEM_BITS'($urandom);
        return item_pool[$urandom_range(7)];
    endfunction

    task automatic send_word(input logic [REQ_BITS-1:0] req, input logic [IDX_BITS-1:0] idx,
                             input logic [POS_BITS-1:0] pos, input logic [ITEM_BITS-1:0] item,
                             input logic eot);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {item, pos, idx};
        s_axis_tuser  <= req;
        s_axis_tlast  <= eot;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(req, idx, pos, item, eot);
        if (req == REQ_LOAD)
            written[idx][pos] = 1'b1;
        if (req != REQ_UNUSED)
            items_sent++;
    endtask

    // Hold the input until every queued report word is out, then idle extra cycles
    task automatic drain(input int extra);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [COUNT_BITS-1:0] min_sup,
                                input logic [SIZE_BITS-1:0] size,
                                input logic [NC_BITS-1:0] count);
        logic [CFG_AW-1:0] addrs [4];
        logic [CFG_DW-1:0] data [4];
        int                n_regs;
        addrs[0] = CFG_SUP_THRESH;
        addrs[1] = CFG_SET_LEN;
        addrs[2] = CFG_CAND_COUNT;
        addrs[3] = CFG_UNUSED;
        // upper bits of the narrow registers carry junk
        data[0]  = min_sup;
        data[1]  = {12'($urandom_range(4095)), size};
        data[2]  = {10'($urandom_range(1023)), count};
        data[3]  = CFG_DW'($urandom);
        n_regs   = ($urandom_range(2) == 0) ? 4 : 3;
        i_cfg_we <= 1'b1;
        for (int r = 0; r < n_regs; r++) begin
            i_cfg_addr <= addrs[r];
            i_cfg_data <= data[r];
            @(posedge i_clk);
            sb.write_reg(addrs[r], data[r]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Fill every in-use position not yet loaded, so no transaction reads stale entries
    task automatic load_missing();
        for (int i = 0; i < sb.used_cands(); i++)
            for (int p = 0; p < sb.used_size(); p++)
                if (!written[i][p])
                    send_word(REQ_LOAD, i[IDX_BITS-1:0], p[POS_BITS-1:0],
                              item_pool[$urandom_range(7)], 1'($urandom));
    endtask

    task automatic send_transaction();
        logic [ITEM_BITS-1:0] items[$];
        int                   c;
        int                   n;
        if (sb.used_size() > 0 && sb.used_cands() > 0 && $urandom_range(99) < 55) begin
            // build around one candidate, sometimes missing one of its items
            c = $urandom_range(sb.used_cands() - 1);
            for (int p = 0; p < sb.used_size(); p++)
                items.insert($urandom_range(items.size()), sb.cand_item[c][p]);
            if ($urandom_range(3) == 0)
                items.delete($urandom_range(items.size() - 1));
            n = $urandom_range(2);
        end else begin
            n = $urandom_range(1, 5);
        end
        repeat (n) items.insert($urandom_range(items.size()), pool_item());
        if (items.size() == 0)
            items.push_back(pool_item());
        for (int k = 0; k < items.size(); k++)
            send_word(REQ_TXN, IDX_BITS'($urandom), POS_BITS'($urandom), items[k],
                      (k == items.size() - 1) && ($urandom_range(19) != 0));
    endtask

    task automatic run_phase(input logic [COUNT_BITS-1:0] min_sup,
                             input logic [SIZE_BITS-1:0] size,
                             input logic [NC_BITS-1:0] count,
                             input int stop_at, input logic hold_off);
        int r;
        drain(8);
        if (items_sent < 160) begin
            send_idle_pct = 25;
            recv_idle_pct = 57;
        end else if (items_sent < 320) begin
            send_idle_pct = 57;
            recv_idle_pct = 25;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        write_config(min_sup, size, count);
        load_missing();
        if (hold_off) begin
            // stall the output while words keep coming in; the second report
            // cannot leave its first word, so the input backs up
            hold_requests++;
            repeat (2) send_word(REQ_REPORT, '0, '0, '0, 1'b0);
        end
        while (items_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 58) begin
                send_transaction();
            end else if (r < 70) begin
                send_word(REQ_REPORT, IDX_BITS'($urandom), POS_BITS'($urandom),
                          ITEM_BITS'($urandom), 1'($urandom));
            end else if (r < 82 && sb.used_cands() > 0) begin
                send_word(REQ_LOAD, IDX_BITS'($urandom_range(sb.used_cands() - 1)),
                          POS_BITS'($urandom), item_pool[$urandom_range(7)], 1'($urandom));
            end else if (r < 88) begin
                send_word(REQ_LOAD, IDX_BITS'($urandom), POS_BITS'($urandom),
                          pool_item(), 1'($urandom));
            end else if (r < 93) begin
                send_word(REQ_UNUSED, IDX_BITS'($urandom), POS_BITS'($urandom),
                          ITEM_BITS'($urandom), 1'($urandom));
            end else if (r < 97) begin
                send_word(REQ_TXN, IDX_BITS'($urandom), POS_BITS'($urandom),
                          pool_item(), 1'b0);
            end else begin
                drain(0);
            end
        end
    endtask

    initial begin
        logic [COUNT_BITS-1:0] ms;
        logic [SIZE_BITS-1:0]  sz;
        logic [NC_BITS-1:0]    nc;
        int                    r;
        sb = new;
        sb.clear();
        foreach (written[i])
            for (int p = 0; p < MAX_ITEMSET; p++)
                written[i][p] = 1'b0;
        item_pool[0] = '0;
        item_pool[1] = '1;
        for (int k = 2; k < 8; k++)
            item_pool[k] = ITEM_BITS'($urandom);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table after reset: nothing found, transactions touch nothing
        send_word(REQ_REPORT, '0, '0, '0, 1'b0);
        send_word(REQ_TXN, '1, '1, '1, 1'b1);
        drain(8);
        write_config(16'd0, 4'd2, 6'd2);
        send_word(REQ_LOAD, 5'd0, 3'd0, 16'h0000, 1'b1);
        send_word(REQ_LOAD, 5'd0, 3'd1, 16'hFFFF, 1'b0);
        send_word(REQ_LOAD, 5'd1, 3'd0, 16'h5A5A, 1'b0);
        send_word(REQ_LOAD, 5'd1, 3'd1, 16'hFFFF, 1'b0);
        send_word(REQ_LOAD, 5'd31, 3'd7, 16'hA5A5, 1'b0);
        send_word(REQ_TXN, 5'd31, 3'd7, 16'h0000, 1'b0);
        send_word(REQ_TXN, '0, '0, 16'hFFFF, 1'b1);
        send_word(REQ_TXN, '0, '0, 16'h5A5A, 1'b0);
        send_word(REQ_TXN, '0, '0, 16'hFFFF, 1'b1);
        send_word(REQ_UNUSED, '1, '1, '1, 1'b1);
        send_word(REQ_REPORT, '1, '1, '1, 1'b1);
        // reload of position zero restarts the count
        send_word(REQ_LOAD, 5'd0, 3'd0, 16'h0000, 1'b0);
        send_word(REQ_REPORT, '0, '0, '0, 1'b0);
        drain(8);
        // empty itemset: every in-use candidate counts on each end mark
        write_config(16'd1, 4'd0, 6'd2);
        send_word(REQ_TXN, '0, '0, 16'h1234, 1'b1);
        send_word(REQ_TXN, '0, '0, 16'h4321, 1'b1);
        send_word(REQ_REPORT, '0, '0, '0, 1'b0);
        drain(8);
        // oversized size and count clamp; no count can reach the top threshold
        write_config(16'hFFFF, 4'd15, 6'd63);
        send_word(REQ_REPORT, '0, '0, '0, 1'b0);

        run_phase(16'd1, 4'd1, 6'd63, 90, 1'b0);
        run_phase(16'd2, 4'd8, 6'd3, 150, 1'b1);
        run_phase(16'd0, 4'd12, 6'd2, 190, 1'b0);
        run_phase(16'd3, 4'd3, 6'd6, 240, 1'b0);
        run_phase(16'd1, 4'd0, 6'd32, 270, 1'b0);
        while (items_sent < ITEM_TARGET) begin
            ms = ($urandom_range(9) == 0) ? 16'hFFFF : COUNT_BITS'($urandom_range(3));
            r  = $urandom_range(9);
            if (r == 0) begin
                sz = 4'd0;
                nc = NC_BITS'($urandom_range(1, 63));
            end else if (r == 1) begin
                sz = SIZE_BITS'($urandom_range(9, 15));
                nc = NC_BITS'($urandom_range(1, 3));
            end else if (r == 2) begin
                sz = SIZE_BITS'($urandom_range(1));
                nc = NC_BITS'($urandom_range(33, 63));
            end else begin
                sz = SIZE_BITS'($urandom_range(1, 4));
                nc = NC_BITS'($urandom_range(1, 12));
            end
            run_phase(ms, sz, nc, items_sent + 45, items_sent > 400 && hold_requests < 2);
        end

        drain(40);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
design/itsc_pkg.sv
design/itsc_cell.sv
design/itsc_report.sv
design/itemset_support_counter.sv
tb/testbench.sv
